[hdl/supply_voltage_monitor_assert.svh]
// Assertion macros shared by the monitor modules.
// Both expect signals named clk and rst in the module that uses them.
`ifndef SUPPLY_VOLTAGE_MONITOR_ASSERT_SVH
`define SUPPLY_VOLTAGE_MONITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("supply voltage monitor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("supply voltage monitor assertion failed");

`endif

[hdl/svm_pkg.sv]
`default_nettype none
package svm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 8;
  localparam int SUM_W    = 24;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int DIV_W    = 34;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] SAT16 = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_BURST   = 4'd0,
    CFG_REFERENCE_MV        = 4'd1,
    CFG_FULL_SCALE_RAW      = 4'd2,
    CFG_DIVIDER_NUMERATOR   = 4'd3,
    CFG_DIVIDER_DENOMINATOR = 4'd4,
    CFG_TRIM_NUMERATOR      = 4'd5,
    CFG_TRIM_DENOMINATOR    = 4'd6,
    CFG_SMOOTHING_SHIFT     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] reference_mv;
    logic [SAMPLE_W-1:0] full_scale_raw;
    logic [SAMPLE_W-1:0] divider_numerator;
    logic [SAMPLE_W-1:0] divider_denominator;
    logic [SAMPLE_W-1:0] trim_numerator;
    logic [SAMPLE_W-1:0] trim_denominator;
    logic [4:0]          smoothing_shift;
  } svm_cfg_t;

  typedef struct packed {
    logic                fail;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
    logic [COUNT_W-1:0]  count;
  } svm_job_t;

endpackage
`default_nettype wire

[hdl/svm_fifo.sv]
`default_nettype none
`include "supply_voltage_monitor_assert.svh"
module svm_fifo
  import svm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire svm_job_t push_data,
  output logic          full,
  input  wire logic     pop,
  output svm_job_t      pop_data,
  output logic          empty
);

  svm_job_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `SVM_ASSERT_NOW(a_no_push_when_full, push, !full)
  `SVM_ASSERT_NOW(a_no_pop_when_empty, pop, !empty)
  `SVM_ASSERT_NOW(a_count_in_range, 1'b1, count <= 2'd2)

endmodule
`default_nettype wire

[hdl/svm_front.sv]
`default_nettype none
module svm_front
  import svm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] raw_sample,
  input  wire logic                read_ok,
  input  wire logic [COUNT_W-1:0]  samples_per_burst,
  input  wire logic                job_full,
  output logic                     job_push,
  output svm_job_t                 job_data
);

  logic [COUNT_W-1:0]  burst_index;
  logic [SUM_W-1:0]    burst_sum;
  logic [SAMPLE_W-1:0] burst_min;
  logic [SAMPLE_W-1:0] burst_max;

  logic                accept;
  logic [COUNT_W:0]    index_next;
  logic [COUNT_W:0]    target;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;
  logic                burst_end;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    target     = (samples_per_burst == '0) ? (COUNT_W+1)'(1)
                                           : {1'b0, samples_per_burst};
    index_next = {1'b0, burst_index} + (COUNT_W+1)'(1);
    if (burst_index == '0) begin
      sum_next = SUM_W'(raw_sample);
      min_next = raw_sample;
      max_next = raw_sample;
    end else begin
      sum_next = burst_sum + SUM_W'(raw_sample);
      min_next = (raw_sample < burst_min) ? raw_sample : burst_min;
      max_next = (raw_sample > burst_max) ? raw_sample : burst_max;
    end
    burst_end = (index_next >= target);
  end

  assign job_push       = accept && (!read_ok || burst_end);
  assign job_data.fail  = !read_ok;
  assign job_data.sum   = sum_next;
  assign job_data.min   = min_next;
  assign job_data.max   = max_next;
  assign job_data.count = index_next[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_index <= '0;
      burst_sum   <= '0;
    end else if (accept) begin
      if (!read_ok || burst_end) begin
        burst_index <= '0;
        burst_sum   <= '0;
      end else begin
        burst_index <= index_next[COUNT_W-1:0];
        burst_sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && read_ok) begin
      burst_min <= min_next;
      burst_max <= max_next;
    end
  end

endmodule
`default_nettype wire

[hdl/svm_div.sv]
`default_nettype none
module svm_div
  import svm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DIV_W-1:0]    dividend,
  input  wire logic [SAMPLE_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DIV_W-1:0]         quotient
);

  logic [SAMPLE_W-1:0]  rem;
  logic [SAMPLE_W-1:0]  div_reg;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SAMPLE_W-1:0]  rem_next;
  logic [DIV_W-1:0]     quo_next;

  // Two restoring steps per cycle.
  always_comb begin
    logic [SAMPLE_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, div_reg}) begin
        trial       = trial - {1'b0, div_reg};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[SAMPLE_W-1:0];
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend;
      rem     <= '0;
      div_reg <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

[hdl/svm_back.sv]
`default_nettype none
`include "supply_voltage_monitor_assert.svh"
module svm_back
  import svm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire svm_cfg_t            cfg,
  input  wire logic                job_empty,
  output logic                     job_pop,
  input  wire svm_job_t            job_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     valid_res,
  output logic [SAMPLE_W-1:0]      mean_raw,
  output logic [SAMPLE_W-1:0]      pin_mv,
  output logic [SAMPLE_W-1:0]      sample_supply_mv,
  output logic [SAMPLE_W-1:0]      filtered_supply_mv
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_TRIM = 15'h0002,
    S_MGO  = 15'h0004,
    S_MDIV = 15'h0008,
    S_PMUL = 15'h0010,
    S_PGO  = 15'h0020,
    S_PDIV = 15'h0040,
    S_RMUL = 15'h0080,
    S_RGO  = 15'h0100,
    S_RDIV = 15'h0200,
    S_TMUL = 15'h0400,
    S_TGO  = 15'h0800,
    S_TDIV = 15'h1000,
    S_FILT = 15'h2000,
    S_DONE = 15'h4000
  } state_t;

  state_t              state;
  svm_job_t            job;
  logic [SUM_W-1:0]    sum_t;
  logic [COUNT_W-1:0]  n_t;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] pin;
  logic [SAMPLE_W-1:0] smp;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] smoothed;
  logic                primed;
  logic [SAMPLE_W-1:0] last_mean_raw;
  logic [SAMPLE_W-1:0] last_pin_mv;
  logic [SAMPLE_W-1:0] last_sample_mv;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [SAMPLE_W-1:0] div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;
  logic [SAMPLE_W-1:0] div_sat;
  logic [SAMPLE_W-1:0] mul_a;
  logic [SAMPLE_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_res;
  logic [SAMPLE_W-1:0] filt_next;
  logic [SAMPLE_W-1:0] step;
  logic                trim_on;
  logic                out_free;

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign out_free = !out_valid || out_ready;
  assign trim_on  = (cfg.trim_numerator != '0) && (cfg.trim_denominator != '0);
  assign div_sat  = (div_quotient[DIV_W-1:SAMPLE_W] != '0) ? SAT16
                                                          : div_quotient[SAMPLE_W-1:0];
  assign mul_res  = mul_a * mul_b;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod);
    div_divisor  = cfg.full_scale_raw;
    mul_a        = mean;
    mul_b        = cfg.reference_mv;
    case (state)
      S_MGO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_t) + DIV_W'(n_t >> 1);
        div_divisor  = SAMPLE_W'(n_t);
      end
      S_PGO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(prod) + DIV_W'(cfg.full_scale_raw >> 1);
        div_divisor  = cfg.full_scale_raw;
      end
      S_RGO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(prod) + DIV_W'(cfg.divider_denominator >> 1);
        div_divisor  = cfg.divider_denominator;
      end
      S_TGO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(prod) + DIV_W'(cfg.trim_denominator >> 1);
        div_divisor  = cfg.trim_denominator;
      end
      S_RMUL: begin
        mul_a = pin;
        mul_b = cfg.divider_numerator;
      end
      S_TMUL: begin
        mul_a = smp;
        mul_b = cfg.trim_numerator;
      end
      default: begin
      end
    endcase
  end

  // The output moves by at least one towards a differing sample.
  always_comb begin
    step = '0;
    if (smp >= smoothed) begin
      step = (smp - smoothed) >> cfg.smoothing_shift;
      if (step == '0 && smp != smoothed) begin
        step = SAMPLE_W'(1);
      end
      filt_next = smoothed + step;
    end else begin
      step = (smoothed - smp) >> cfg.smoothing_shift;
      if (step == '0) begin
        step = SAMPLE_W'(1);
      end
      filt_next = smoothed - step;
    end
    if (cfg.smoothing_shift == '0 || !primed) begin
      filt_next = smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      smoothed       <= '0;
      primed         <= 1'b0;
      last_mean_raw  <= '0;
      last_pin_mv    <= '0;
      last_sample_mv <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job   <= job_data;
            state <= job_data.fail ? S_DONE : S_TRIM;
          end
        end
        S_TRIM: begin
          if (job.count > COUNT_W'(2)) begin
            sum_t <= job.sum - SUM_W'(job.min) - SUM_W'(job.max);
            n_t   <= job.count - COUNT_W'(2);
          end else begin
            sum_t <= job.sum;
            n_t   <= job.count;
          end
          state <= S_MGO;
        end
        S_MGO: begin
          state <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            mean  <= div_quotient[SAMPLE_W-1:0];
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (cfg.full_scale_raw == '0) begin
            pin   <= '0;
            state <= S_RMUL;
          end else begin
            prod  <= mul_res;
            state <= S_PGO;
          end
        end
        S_PGO: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            pin   <= div_quotient[SAMPLE_W-1:0];
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          if (cfg.divider_denominator == '0) begin
            smp   <= '0;
            state <= S_TMUL;
          end else begin
            prod  <= mul_res;
            state <= S_RGO;
          end
        end
        S_RGO: begin
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (div_done) begin
            smp   <= div_sat;
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          if (trim_on) begin
            prod  <= mul_res;
            state <= S_TGO;
          end else begin
            state <= S_FILT;
          end
        end
        S_TGO: begin
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            smp   <= div_sat;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          smoothed       <= filt_next;
          primed         <= 1'b1;
          last_mean_raw  <= mean;
          last_pin_mv    <= pin;
          last_sample_mv <= smp;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      valid_res          <= !job.fail;
      mean_raw           <= last_mean_raw;
      pin_mv             <= last_pin_mv;
      sample_supply_mv   <= last_sample_mv;
      filtered_supply_mv <= smoothed;
    end
  end

  `SVM_ASSERT_NOW(a_div_start_idle, div_start, !div_busy)
  `SVM_ASSERT_NEXT(a_filter_bypass, state == S_FILT && cfg.smoothing_shift == '0,
                   smoothed == last_sample_mv)
  `SVM_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == S_DONE))

endmodule
`default_nettype wire

[hdl/supply_voltage_monitor.sv]
// A sample is taken whenever the queue is not full, whether or not it ends a burst.
// A completed burst gives its result after serial divisions for the mean, pin voltage
// and divider ratio, plus the trim with calibration on, at two quotient bits a cycle;
// a zero full scale or divider denominator skips its division. A failed read skips them all.
// The back end takes the next of up to two queued requests the cycle after loading a result.
// Reset is synchronous and active high; it restores register defaults and control state.
`default_nettype none
module supply_voltage_monitor
  import svm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   raw_sample,
  input  wire logic                  read_ok,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       valid_res,
  output logic [SAMPLE_W-1:0]        mean_raw,
  output logic [SAMPLE_W-1:0]        pin_mv,
  output logic [SAMPLE_W-1:0]        sample_supply_mv,
  output logic [SAMPLE_W-1:0]        filtered_supply_mv,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] samples_per_burst;
  svm_cfg_t           cfg;
  logic               job_push;
  logic               job_pop;
  logic               job_full;
  logic               job_empty;
  svm_job_t           job_in;
  svm_job_t           job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_burst       <= COUNT_W'(1);
      cfg.reference_mv        <= SAMPLE_W'(3300);
      cfg.full_scale_raw      <= SAMPLE_W'(4095);
      cfg.divider_numerator   <= SAMPLE_W'(1);
      cfg.divider_denominator <= SAMPLE_W'(1);
      cfg.trim_numerator      <= '0;
      cfg.trim_denominator    <= '0;
      cfg.smoothing_shift     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SAMPLES_PER_BURST:   samples_per_burst       <= cfg_data[COUNT_W-1:0];
        CFG_REFERENCE_MV:        cfg.reference_mv        <= cfg_data;
        CFG_FULL_SCALE_RAW:      cfg.full_scale_raw      <= cfg_data;
        CFG_DIVIDER_NUMERATOR:   cfg.divider_numerator   <= cfg_data;
        CFG_DIVIDER_DENOMINATOR: cfg.divider_denominator <= cfg_data;
        CFG_TRIM_NUMERATOR:      cfg.trim_numerator      <= cfg_data;
        CFG_TRIM_DENOMINATOR:    cfg.trim_denominator    <= cfg_data;
        CFG_SMOOTHING_SHIFT:     cfg.smoothing_shift     <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  svm_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .raw_sample        (raw_sample),
    .read_ok           (read_ok),
    .samples_per_burst (samples_per_burst),
    .job_full          (job_full),
    .job_push          (job_push),
    .job_data          (job_in)
  );

  svm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  svm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .job_data           (job_out),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .valid_res          (valid_res),
    .mean_raw           (mean_raw),
    .pin_mv             (pin_mv),
    .sample_supply_mv   (sample_supply_mv),
    .filtered_supply_mv (filtered_supply_mv)
  );

endmodule
`default_nettype wire

[tb/tb_supply_voltage_monitor.sv]
module tb_supply_voltage_monitor;
  import svm_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_COUNT = 13;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 4'd15;

  typedef struct packed {
    logic                valid_res;
    logic [SAMPLE_W-1:0] mean_raw;
    logic [SAMPLE_W-1:0] pin_mv;
    logic [SAMPLE_W-1:0] raw_supply;
    logic [SAMPLE_W-1:0] avg_supply;
  } supply_reading_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [SAMPLE_W-1:0] raw_sample;
  logic read_ok;
  logic out_valid;
  logic out_ready;
  logic valid_res;
  logic [SAMPLE_W-1:0] mean_raw;
  logic [SAMPLE_W-1:0] pin_mv;
  logic [SAMPLE_W-1:0] sample_supply_mv;
  logic [SAMPLE_W-1:0] filtered_supply_mv;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit idle_en = 1'b1;
  int fail_count = 0;
  int stall_left = 0;
  supply_reading_t expected_readings[$];
  supply_reading_t want;

  logic [7:0]          cfg_burst_len = 8'd1;
  logic [SAMPLE_W-1:0] cfg_ref = 16'd3300;
  logic [SAMPLE_W-1:0] cfg_fs = 16'd4095;
  logic [SAMPLE_W-1:0] cfg_div_num = 16'd1;
  logic [SAMPLE_W-1:0] cfg_div_den = 16'd1;
  logic [SAMPLE_W-1:0] cfg_trim_num = 16'd0;
  logic [SAMPLE_W-1:0] cfg_trim_den = 16'd0;
  logic [4:0]          cfg_shift = 5'd0;

  logic [8:0]          burst_count = '0;
  logic [23:0]         burst_total = '0;
  logic [SAMPLE_W-1:0] burst_lo = '0;
  logic [SAMPLE_W-1:0] burst_hi = '0;
  logic [SAMPLE_W-1:0] smoothed = '0;
  logic [SAMPLE_W-1:0] last_mean = '0;
  logic [SAMPLE_W-1:0] last_pin = '0;
  logic [SAMPLE_W-1:0] last_smp = '0;
  bit                  filter_primed = 1'b0;

  supply_voltage_monitor uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .raw_sample(raw_sample),
    .read_ok(read_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .valid_res(valid_res),
    .mean_raw(mean_raw),
    .pin_mv(pin_mv),
    .sample_supply_mv(sample_supply_mv),
    .filtered_supply_mv(filtered_supply_mv),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic note_failure(input string text);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", text);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] scaled_ratio(input logic [SAMPLE_W-1:0] v,
                                                       input logic [SAMPLE_W-1:0] num,
                                                       input logic [SAMPLE_W-1:0] den);
    logic [63:0] q;
    if (den == 0) begin
      return '0;
    end
    q = (64'(v) * 64'(num) + 64'(den >> 1)) / 64'(den);
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic predict_reading(input logic [SAMPLE_W-1:0] x, input logic ok);
    supply_reading_t r;
    logic [8:0] target;
    logic [31:0] n, total, y, d;
    logic [63:0] wide;
    logic [SAMPLE_W-1:0] mean, pin, smp;
    if (!ok) begin
      burst_count = '0;
      burst_total = '0;
      r = '{1'b0, last_mean, last_pin, last_smp, smoothed};
      expected_readings.push_back(r);
    end else begin
      if (burst_count == 0) begin
        burst_lo = x;
        burst_hi = x;
        burst_total = 24'(x);
      end else begin
        if (x < burst_lo) burst_lo = x;
        if (x > burst_hi) burst_hi = x;
        burst_total = burst_total + 24'(x);
      end
      burst_count = burst_count + 9'd1;
      target = (cfg_burst_len == 0) ? 9'd1 : {1'b0, cfg_burst_len};
      if (burst_count >= target) begin
        n = 32'(burst_count);
        total = 32'(burst_total);
        if (n > 2) begin
          total = (total - 32'(burst_lo) - 32'(burst_hi)) & 32'hFF_FFFF;
          n = n - 2;
        end
        y = (total + n / 2) / n;
        mean = y[15:0];
        burst_count = '0;
        burst_total = '0;
        if (cfg_fs == 0) begin
          pin = '0;
        end else begin
          wide = (64'(mean) * 64'(cfg_ref) + 64'(cfg_fs >> 1)) / 64'(cfg_fs);
          pin = wide[15:0];
        end
        smp = scaled_ratio(pin, cfg_div_num, cfg_div_den);
        if (cfg_trim_num != 0 && cfg_trim_den != 0) begin
          smp = scaled_ratio(smp, cfg_trim_num, cfg_trim_den);
        end
        if (cfg_shift == 0 || !filter_primed) begin
          filter_primed = 1'b1;
          smoothed = smp;
        end else begin
          y = 32'(smoothed);
          if (smp >= smoothed) begin
            d = (32'(smp) - y) >> cfg_shift;
            if (d == 0 && smp != smoothed) d = 1;
            y = y + d;
          end else begin
            d = (y - 32'(smp)) >> cfg_shift;
            if (d == 0) d = 1;
            y = y - d;
          end
          smoothed = (y > 32'hFFFF) ? 16'hFFFF : y[15:0];
        end
        last_mean = mean;
        last_pin = pin;
        last_smp = smp;
        r = '{1'b1, mean, pin, smp, smoothed};
        expected_readings.push_back(r);
      end
    end
  endtask

  // The request stays valid, with its payload unchanged, until the block takes it.
  task automatic send_reading(input logic [SAMPLE_W-1:0] x, input logic ok);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    raw_sample = x;
    read_ok = ok;
    do @(posedge clk); while (!in_ready);
    predict_reading(x, ok);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLES_PER_BURST:   cfg_burst_len = data[7:0];
      CFG_REFERENCE_MV:        cfg_ref = data;
      CFG_FULL_SCALE_RAW:      cfg_fs = data;
      CFG_DIVIDER_NUMERATOR:   cfg_div_num = data;
      CFG_DIVIDER_DENOMINATOR: cfg_div_den = data;
      CFG_TRIM_NUMERATOR:      cfg_trim_num = data;
      CFG_TRIM_DENOMINATOR:    cfg_trim_den = data;
      CFG_SMOOTHING_SHIFT:     cfg_shift = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once every reading has come out and the back end has settled.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_setting(input int unsigned lo,
                                                       input int unsigned hi);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        note_failure($sformatf("unexpected reading: valid=%0d mean=%h pin=%h smp=%h filt=%h",
                               valid_res, mean_raw, pin_mv, sample_supply_mv,
                               filtered_supply_mv));
      end else begin
        want = expected_readings.pop_front();
        if (want.valid_res !== valid_res || want.mean_raw !== mean_raw ||
            want.pin_mv !== pin_mv || want.raw_supply !== sample_supply_mv ||
            want.avg_supply !== filtered_supply_mv) begin
          note_failure($sformatf({"reading mismatch: expected valid=%0d mean=%h pin=%h ",
                                  "smp=%h filt=%h, got valid=%0d mean=%h pin=%h smp=%h filt=%h"},
                                 want.valid_res, want.mean_raw, want.pin_mv, want.raw_supply,
                                 want.avg_supply, valid_res, mean_raw, pin_mv,
                                 sample_supply_mv, filtered_supply_mv));
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_reading(16'h5A5A, 1'b0);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'd4095, 1'b1);
    send_reading(16'hA5A5, 1'b0);
  endtask

  task automatic test_burst_handling();
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd0);
    send_reading(16'h1234, 1'b1);
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd2);
    send_reading(16'd100, 1'b1);
    send_reading(16'd101, 1'b1);
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd3);
    send_reading(16'd5, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'd9, 1'b1);
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd4);
    send_reading(16'd10, 1'b1);
    send_reading(16'd20, 1'b1);
    send_reading(16'hABCD, 1'b0);
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd5);
    send_reading(16'd40, 1'b1);
    send_reading(16'd50, 1'b1);
    send_reading(16'd60, 1'b1);
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd2);
    send_reading(16'd70, 1'b1);
  endtask

  task automatic test_scaling_limits();
    wait_idle();
    cfg_write(CFG_SAMPLES_PER_BURST, 16'd1);
    cfg_write(CFG_FULL_SCALE_RAW, 16'd0);
    send_reading(16'd1000, 1'b1);
    wait_idle();
    cfg_write(CFG_FULL_SCALE_RAW, 16'd1);
    cfg_write(CFG_REFERENCE_MV, 16'hFFFF);
    cfg_write(CFG_DIVIDER_DENOMINATOR, 16'd0);
    send_reading(16'hFFFF, 1'b1);
    wait_idle();
    cfg_write(CFG_DIVIDER_DENOMINATOR, 16'd1);
    cfg_write(CFG_DIVIDER_NUMERATOR, 16'hFFFF);
    cfg_write(CFG_TRIM_NUMERATOR, 16'hFFFF);
    cfg_write(CFG_TRIM_DENOMINATOR, 16'd1);
    send_reading(16'd3, 1'b1);
    wait_idle();
    cfg_write(CFG_TRIM_NUMERATOR, 16'd1);
    cfg_write(CFG_TRIM_DENOMINATOR, 16'hFFFF);
    cfg_write(CFG_SMOOTHING_SHIFT, 16'd31);
    cfg_write(SPARE_INDEX_LO, 16'h0000);
    cfg_write(SPARE_INDEX_HI, 16'hFFFF);
    send_reading(16'd3, 1'b1);
    wait_idle();
    cfg_write(CFG_TRIM_DENOMINATOR, 16'd0);
    send_reading(16'd3, 1'b1);
    wait_idle();
    cfg_write(CFG_SMOOTHING_SHIFT, 16'd1);
    cfg_write(CFG_DIVIDER_NUMERATOR, 16'd1);
    send_reading(16'd7, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [7:0] len;
    logic [4:0] shift;
    logic [SAMPLE_W-1:0] centre, x;
    bit spread;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_en = (phase < PHASE_COUNT - 2);
      wait_idle();
      case ($urandom_range(0, 9))
        0: len = 8'd0;
        1: len = 8'd255;
        2: len = 8'($urandom_range(9, 64));
        default: len = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 5))
        0: shift = 5'd0;
        1: shift = 5'd31;
        default: shift = 5'($urandom_range(1, 6));
      endcase
      cfg_write(CFG_SAMPLES_PER_BURST, {8'($urandom), len});
      cfg_write(CFG_REFERENCE_MV, pick_setting(1000, 5000));
      cfg_write(CFG_FULL_SCALE_RAW, pick_setting(255, 4095));
      cfg_write(CFG_DIVIDER_NUMERATOR, pick_setting(1, 16));
      cfg_write(CFG_DIVIDER_DENOMINATOR, pick_setting(1, 16));
      cfg_write(CFG_TRIM_NUMERATOR, pick_setting(900, 1100));
      cfg_write(CFG_TRIM_DENOMINATOR, pick_setting(900, 1100));
      cfg_write(CFG_SMOOTHING_SHIFT, {11'($urandom), shift});
      centre = 16'($urandom);
      spread = 1'($urandom_range(0, 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (spread || $urandom_range(0, 3) == 0) begin
          x = 16'($urandom);
        end else begin
          x = centre + 16'($urandom_range(0, 63)) - 16'd32;
        end
        send_reading(x, $urandom_range(0, 19) != 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    raw_sample = '0;
    read_ok = 1'b0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_burst_handling();
    test_scaling_limits();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
